// File: rtl/barometer_compensation_macros.svh
// Assertion macros for the barometer compensation RTL.
// Used by the top level and the divider; expects clk and rst_n in scope.
`ifndef BAROMETER_COMPENSATION_MACROS_SVH
`define BAROMETER_COMPENSATION_MACROS_SVH
`ifndef ASSERT_OFF
`define BARO_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("baro assertion failed");
`define BARO_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("baro forbidden condition");
`else
`define BARO_ASSERT(label, prop)
`define BARO_ASSERT_NEVER(label, cond)
`endif
`endif

// File: rtl/baro_pkg.sv
// Package for the barometer compensation block: payload types, register
// indexes and fixed-point constants. No dependencies.
package baro_pkg;

    localparam int DIV_W  = 32;
    localparam int SIDE_W = 53;
    localparam int UP_W   = 19;

    localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
    localparam logic signed [31:0] B4_OFFSET = 32'sd32768;
    localparam logic        [31:0] B7_SCALE  = 32'd50000;
    localparam logic signed [31:0] PC_SQ     = 32'sd3038;
    localparam logic signed [31:0] PC_LIN    = -32'sd7357;
    localparam logic signed [31:0] PC_OFS    = 32'sd3791;
    localparam logic signed [31:0] T_MAX     = 32'sd32767;
    localparam logic signed [31:0] T_MIN     = -32'sd32768;
    localparam logic signed [31:0] P_MAX     = 32'sd262143;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic        [17:0] pressure_pascal;
        logic               divide_fault;
    } out_item_t;

    // sideband carried beside the temperature divider
    typedef struct packed {
        logic signed [31:0] x1;
        logic               neg;
        logic               fault;
        logic [UP_W-1:0]    up;
    } div1_side_t;

    // sideband carried beside the pressure divider
    typedef struct packed {
        logic signed [15:0] t;
        logic               fault;
        logic               post;
    } div2_side_t;

endpackage

// File: rtl/barometer_compensation.sv
// Top level of the barometer compensation pipeline: configuration
// registers, multiply stages and two baro_divider instances. Uses baro_pkg.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_item  (raw temperature, raw pressure)
//   out     | output    | out_valid / out_stall| out_item (tenths, pascals, fault)
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One request per cycle unless a stalled output holds the pipe; two 32-stage dividers make up most stages.
// Reset clears all valid bits and loads oversampling 3, coefficients 0.
// A stall at the output holds every stage; in_stall is high exactly then.
// Calibration is read live, so it must only change with the pipe empty.
`include "barometer_compensation_macros.svh"
module barometer_compensation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  baro_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output baro_pkg::out_item_t out_item,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import baro_pkg::*;

    localparam int D2_W   = $bits(div2_side_t);
    localparam int D2_PAD = SIDE_W - D2_W;

    // configuration
    logic [31:0] cal_ac1_ac2_reg, cal_ac3_ac4_reg, cal_ac5_ac6_reg;
    logic [31:0] cal_b1_b2_reg, cal_mc_md_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_ac1_ac2_reg <= '0;
            cal_ac3_ac4_reg <= '0;
            cal_ac5_ac6_reg <= '0;
            cal_b1_b2_reg   <= '0;
            cal_mc_md_reg   <= '0;
            oss_reg         <= 2'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_AC1_AC2: cal_ac1_ac2_reg <= cfg_data;
                REG_AC3_AC4: cal_ac3_ac4_reg <= cfg_data;
                REG_AC5_AC6: cal_ac5_ac6_reg <= cfg_data;
                REG_B1_B2:   cal_b1_b2_reg   <= cfg_data;
                REG_MC_MD:   cal_mc_md_reg   <= cfg_data;
                REG_OSS:     oss_reg         <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic        [31:0] ac4, ac5, ac6;
    assign ac1 = {{16{cal_ac1_ac2_reg[31]}}, cal_ac1_ac2_reg[31:16]};
    assign ac2 = {{16{cal_ac1_ac2_reg[15]}}, cal_ac1_ac2_reg[15:0]};
    assign ac3 = {{16{cal_ac3_ac4_reg[31]}}, cal_ac3_ac4_reg[31:16]};
    assign ac4 = {16'd0, cal_ac3_ac4_reg[15:0]};
    assign ac5 = {16'd0, cal_ac5_ac6_reg[31:16]};
    assign ac6 = {16'd0, cal_ac5_ac6_reg[15:0]};
    assign b1  = {{16{cal_b1_b2_reg[31]}}, cal_b1_b2_reg[31:16]};
    assign b2  = {{16{cal_b1_b2_reg[15]}}, cal_b1_b2_reg[15:0]};
    assign mc  = {{16{cal_mc_md_reg[31]}}, cal_mc_md_reg[31:16]};
    assign md  = {{16{cal_mc_md_reg[15]}}, cal_mc_md_reg[15:0]};

    logic en;
    logic out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // stage A: (ut - ac6) * ac5, pressure alignment
    logic               a_valid_reg;
    logic signed [31:0] a_m1_reg, a_m1_next, a_ut;
    logic [UP_W-1:0]    a_up_reg, a_up_next;

    assign a_ut      = {16'd0, in_item.raw_temperature};
    assign a_m1_next = (a_ut - ac6) * ac5;
    assign a_up_next = UP_W'(in_item.raw_pressure >> (4'd8 - {2'b00, oss_reg}));

    // stage B: denominator, magnitudes for the divider
    logic               b_valid_reg;
    logic [31:0]        b_num_reg, b_num_next, b_den_reg, b_den_next;
    div1_side_t         b_side_reg, b_side_next;
    logic signed [31:0] b_x1, b_den_s, b_num_s;

    always_comb
    begin
        b_x1    = a_m1_reg >>> 15;
        b_den_s = b_x1 + md;
        b_num_s = mc <<< 11;
        b_num_next = b_num_s[31] ? 32'(-b_num_s) : b_num_s;
        b_den_next = b_den_s[31] ? 32'(-b_den_s) : b_den_s;
        b_side_next.x1    = b_x1;
        b_side_next.neg   = b_num_s[31] ^ b_den_s[31];
        b_side_next.fault = (b_den_s == '0);
        b_side_next.up    = a_up_reg;
    end

    logic              d1_valid;
    logic [31:0]       d1_q;
    logic [SIDE_W-1:0] d1_side_vec;
    div1_side_t        d1_side;

    baro_divider u_div_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .dividend  (b_num_reg),
        .divisor   (b_den_reg),
        .side_in   (b_side_reg),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .side_out  (d1_side_vec)
    );
    assign d1_side = d1_side_vec;

    // stage C: b5, temperature, b6 products
    logic               c_valid_reg;
    logic signed [31:0] c_x2, c_b5, c_tw, c_b6;
    logic signed [31:0] c_sqf_reg, c_sqf_next, c_mac2_reg, c_mac2_next;
    logic signed [31:0] c_mac3_reg, c_mac3_next;
    logic signed [15:0] c_t_reg, c_t_next;
    logic               c_fault_reg;
    logic [UP_W-1:0]    c_up_reg;

    always_comb
    begin
        c_x2 = d1_side.neg ? 32'(-d1_q) : d1_q;
        c_b5 = d1_side.x1 + c_x2;
        c_tw = (c_b5 + 32'sd8) >>> 4;
        c_b6 = c_b5 - B6_OFFSET;
        if (c_tw > T_MAX)
            c_t_next = T_MAX[15:0];
        else if (c_tw < T_MIN)
            c_t_next = T_MIN[15:0];
        else
            c_t_next = c_tw[15:0];
        c_sqf_next  = c_b6 * c_b6;
        c_mac2_next = ac2 * c_b6;
        c_mac3_next = ac3 * c_b6;
    end

    // stage D: coefficient times squared term
    logic               d_valid_reg;
    logic signed [31:0] d_sq;
    logic signed [31:0] d_b2sq_reg, d_b2sq_next, d_b1sq_reg, d_b1sq_next;
    logic signed [31:0] d_x2a_reg, d_x2a_next, d_x1c_reg, d_x1c_next;
    logic signed [15:0] d_t_reg;
    logic               d_fault_reg;
    logic [UP_W-1:0]    d_up_reg;

    assign d_sq        = c_sqf_reg >>> 12;
    assign d_b2sq_next = b2 * d_sq;
    assign d_b1sq_next = b1 * d_sq;
    assign d_x2a_next  = c_mac2_reg >>> 11;
    assign d_x1c_next  = c_mac3_reg >>> 13;

    // stage E: b3 and the b4 offset term
    logic               e_valid_reg;
    logic signed [31:0] e_x1, e_x3, e_s, e_s2, e_x2b;
    logic signed [31:0] e_b3_reg, e_b3_next, e_x3b_reg, e_x3b_next;
    logic signed [15:0] e_t_reg;
    logic               e_fault_reg;
    logic [UP_W-1:0]    e_up_reg;

    always_comb
    begin
        e_x1       = d_b2sq_reg >>> 11;
        e_x3       = e_x1 + d_x2a_reg;
        e_s        = (ac1 <<< 2) + e_x3;
        e_s2       = e_s << oss_reg;
        e_b3_next  = (e_s2 + 32'sd2) >>> 2;
        e_x2b      = d_b1sq_reg >>> 16;
        e_x3b_next = (d_x1c_reg + e_x2b + 32'sd2) >>> 2;
    end

    // stage F: b4 and b7
    logic               f_valid_reg;
    logic [31:0]        f_b4full, f_up32, f_b7_reg, f_b7_next;
    logic [16:0]        f_b4_reg, f_b4_next;
    logic signed [15:0] f_t_reg;
    logic               f_fault_reg;

    assign f_b4full  = ac4 * (e_x3b_reg + B4_OFFSET);
    assign f_b4_next = 17'(f_b4full >> 15);
    assign f_up32    = {{(32-UP_W){1'b0}}, e_up_reg};
    assign f_b7_next = (f_up32 - e_b3_reg) * (B7_SCALE >> oss_reg);

    // second divider: b7 * 2 / b4, doubling after the divide for large b7
    div2_side_t        d2_in, d2_out;
    logic [31:0]       d2_dividend;
    logic              d2_valid;
    logic [31:0]       d2_q;
    logic [SIDE_W-1:0] d2_side_vec;

    always_comb
    begin
        d2_in.t     = f_t_reg;
        d2_in.fault = f_fault_reg || (f_b4_reg == '0);
        d2_in.post  = f_b7_reg[31];
        d2_dividend = f_b7_reg[31] ? f_b7_reg : {f_b7_reg[30:0], 1'b0};
    end

    baro_divider u_div_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid_reg),
        .dividend  (d2_dividend),
        .divisor   ({15'd0, f_b4_reg}),
        .side_in   ({{D2_PAD{1'b0}}, d2_in}),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .side_out  (d2_side_vec)
    );
    assign d2_out = d2_side_vec[D2_W-1:0];

    // stage H: pressure correction products
    logic               h_valid_reg;
    logic signed [31:0] h_p, h_q8;
    logic signed [31:0] h_p_reg, h_sqp_reg, h_sqp_next, h_lin_reg, h_lin_next;
    logic signed [15:0] h_t_reg;
    logic               h_fault_reg;

    assign h_p        = d2_out.post ? {d2_q[30:0], 1'b0} : d2_q;
    assign h_q8       = h_p >>> 8;
    assign h_sqp_next = h_q8 * h_q8;
    assign h_lin_next = PC_LIN * h_p;

    // stage I: square term scaling
    logic               i_valid_reg;
    logic signed [31:0] i_m_reg, i_m_next, i_p_reg, i_lin_reg;
    logic signed [15:0] i_t_reg;
    logic               i_fault_reg;

    assign i_m_next = h_sqp_reg * PC_SQ;

    // stage J: final sum and saturation
    logic signed [31:0] j_x1, j_x2, j_corr, j_pf;

    always_comb
    begin
        j_x1   = i_m_reg >>> 16;
        j_x2   = i_lin_reg >>> 16;
        j_corr = (j_x1 + j_x2 + PC_OFS) >>> 4;
        j_pf   = i_p_reg + j_corr;
        out_item_next.divide_fault       = i_fault_reg;
        out_item_next.temperature_tenths = i_fault_reg ? 16'sd0 : i_t_reg;
        if (i_fault_reg || j_pf < 0)
            out_item_next.pressure_pascal = '0;
        else if (j_pf > P_MAX)
            out_item_next.pressure_pascal = P_MAX[17:0];
        else
            out_item_next.pressure_pascal = j_pf[17:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= d1_valid;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            h_valid_reg   <= d2_valid;
            i_valid_reg   <= h_valid_reg;
            out_valid_reg <= i_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_m1_reg     <= a_m1_next;
            a_up_reg     <= a_up_next;
            b_num_reg    <= b_num_next;
            b_den_reg    <= b_den_next;
            b_side_reg   <= b_side_next;
            c_sqf_reg    <= c_sqf_next;
            c_mac2_reg   <= c_mac2_next;
            c_mac3_reg   <= c_mac3_next;
            c_t_reg      <= c_t_next;
            c_fault_reg  <= d1_side.fault;
            c_up_reg     <= d1_side.up;
            d_b2sq_reg   <= d_b2sq_next;
            d_b1sq_reg   <= d_b1sq_next;
            d_x2a_reg    <= d_x2a_next;
            d_x1c_reg    <= d_x1c_next;
            d_t_reg      <= c_t_reg;
            d_fault_reg  <= c_fault_reg;
            d_up_reg     <= c_up_reg;
            e_b3_reg     <= e_b3_next;
            e_x3b_reg    <= e_x3b_next;
            e_t_reg      <= d_t_reg;
            e_fault_reg  <= d_fault_reg;
            e_up_reg     <= d_up_reg;
            f_b4_reg     <= f_b4_next;
            f_b7_reg     <= f_b7_next;
            f_t_reg      <= e_t_reg;
            f_fault_reg  <= e_fault_reg;
            h_p_reg      <= h_p;
            h_sqp_reg    <= h_sqp_next;
            h_lin_reg    <= h_lin_next;
            h_t_reg      <= d2_out.t;
            h_fault_reg  <= d2_out.fault;
            i_m_reg      <= i_m_next;
            i_p_reg      <= h_p_reg;
            i_lin_reg    <= h_lin_reg;
            i_t_reg      <= h_t_reg;
            i_fault_reg  <= h_fault_reg;
            out_item_reg <= out_item_next;
        end
    end

    // a faulted result carries zero payload
    `BARO_ASSERT(a_fault_zero, out_valid_reg && out_item_reg.divide_fault |-> (out_item_reg.temperature_tenths == 16'sd0) && (out_item_reg.pressure_pascal == '0))
    // an accepted request lands in the first stage
    `BARO_ASSERT(a_accept_lands, in_valid && !in_stall |=> a_valid_reg)
    // a stalled result stays put
    `BARO_ASSERT(a_stall_holds, out_valid_reg && out_stall |=> out_valid_reg && $stable(out_item_reg))

endmodule

// File: rtl/baro_divider.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage,
// with a sideband word that travels with each request. Uses baro_pkg.
`include "barometer_compensation_macros.svh"
module baro_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [baro_pkg::DIV_W-1:0]  dividend,
    input  logic [baro_pkg::DIV_W-1:0]  divisor,
    input  logic [baro_pkg::SIDE_W-1:0] side_in,
    output logic                      out_valid,
    output logic [baro_pkg::DIV_W-1:0]  quotient,
    output logic [baro_pkg::SIDE_W-1:0] side_out
);
    import baro_pkg::*;

    logic              vld_reg [DIV_W];
    logic [DIV_W-1:0]  rem_reg [DIV_W];
    logic [DIV_W-1:0]  quo_reg [DIV_W];
    logic [DIV_W-1:0]  dvs_reg [DIV_W];
    logic [SIDE_W-1:0] sd_reg  [DIV_W];

    for (genvar i = 0; i < DIV_W; i++) begin : g_step
        logic              v_in;
        logic [DIV_W-1:0]  r_in;
        logic [DIV_W-1:0]  q_in;
        logic [DIV_W-1:0]  d_in;
        logic [SIDE_W-1:0] s_in;
        logic [DIV_W:0]    trial;
        logic [DIV_W:0]    diff;
        logic              ge;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign q_in = dividend;
            assign d_in = divisor;
            assign s_in = side_in;
        end
        else begin : g_next
            assign v_in = vld_reg[i-1];
            assign r_in = rem_reg[i-1];
            assign q_in = quo_reg[i-1];
            assign d_in = dvs_reg[i-1];
            assign s_in = sd_reg[i-1];
        end

        assign trial = {r_in, q_in[DIV_W-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                quo_reg[i] <= {q_in[DIV_W-2:0], ge};
                dvs_reg[i] <= d_in;
                sd_reg[i]  <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_W-1];
    assign quotient  = quo_reg[DIV_W-1];
    assign side_out  = sd_reg[DIV_W-1];

    // final remainder must be below a nonzero divisor
    `BARO_ASSERT(a_rem_below_divisor, vld_reg[DIV_W-1] && (dvs_reg[DIV_W-1] != '0) |-> rem_reg[DIV_W-1] < dvs_reg[DIV_W-1])

endmodule
